FILE: rtl/mep_pkg.sv
// ----------------------------------------------------------------------------
// mep_pkg: shared types, constants and microcode for the escape-time pixel
// Holds the beat structs, the configuration set, the control word layout and
// the read-only control program that sequences the datapath.
// ----------------------------------------------------------------------------
package mep_pkg;

    // Fixed-point format and limits
    localparam int FRAC_BITS = 28;
    localparam int MAX_DIM   = 4096;
    localparam int MAX_ITER  = 4096;

    localparam int IDX_W    = $clog2(MAX_DIM);
    localparam int CNT_W    = $clog2(MAX_ITER) + 1;
    localparam int GRAY_W   = 8;
    localparam int C_W      = 32;
    localparam int STEP_W   = 31;
    localparam int CPROD_W  = IDX_W + STEP_W;
    localparam int CSUM_W   = CPROD_W + 2;
    localparam int Z_W      = 36;
    localparam int OP_W     = 32;
    localparam int PROD_W   = 2 * OP_W;
    localparam int NORM_W   = Z_W + 1;
    localparam int REM_W    = CNT_W + GRAY_W - 1;
    localparam int DIVK_W   = $clog2(GRAY_W);

    localparam logic [CNT_W-1:0]  MAX_ITER_VAL = CNT_W'(MAX_ITER);
    localparam logic [NORM_W-1:0] ESC_BOUND    = NORM_W'(4) << FRAC_BITS;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITERATIONS = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_RE      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_IM      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_RE        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_IM        = 3'd4;

    localparam logic [CNT_W-1:0]  RST_MAX_ITERATIONS = 13'd2048;
    localparam logic [C_W-1:0]    RST_ORIGIN_RE      = 32'hE800_0000;
    localparam logic [C_W-1:0]    RST_ORIGIN_IM      = 32'hF000_0000;
    localparam logic [STEP_W-1:0] RST_STEP_RE        = 31'd268435;
    localparam logic [STEP_W-1:0] RST_STEP_IM        = 31'd268435;

    typedef struct packed {
        logic [IDX_W-1:0] pixel_col;
        logic [IDX_W-1:0] pixel_row;
    } pix_in_t;

    typedef struct packed {
        logic [CNT_W-1:0]  escape_count;
        logic [GRAY_W-1:0] gray_level;
    } pix_out_t;

    typedef struct packed {
        logic [CNT_W-1:0]  max_iterations;
        logic [C_W-1:0]    origin_re;
        logic [C_W-1:0]    origin_im;
        logic [STEP_W-1:0] step_re;
        logic [STEP_W-1:0] step_im;
    } cfg_t;

    // Microcode
    typedef logic [2:0] ustep_t;

    localparam ustep_t STEP_IDLE  = 3'd0;
    localparam ustep_t STEP_CMUL  = 3'd1;
    localparam ustep_t STEP_CSUM  = 3'd2;
    localparam ustep_t STEP_TMUL  = 3'd3;
    localparam ustep_t STEP_UPD   = 3'd4;
    localparam ustep_t STEP_DINIT = 3'd5;
    localparam ustep_t STEP_DIV   = 3'd6;
    localparam ustep_t STEP_OUT   = 3'd7;

    typedef enum logic [1:0] {
        WAIT_NONE,
        WAIT_INPUT,
        WAIT_OUTPUT,
        WAIT_DIV
    } wait_t;

    typedef enum logic [1:0] {
        BR_NEXT,
        BR_ALWAYS,
        BR_DONE
    } branch_t;

    typedef struct packed {
        logic    load_in;
        logic    coord_mul;
        logic    coord_sum;
        logic    iter_mul;
        logic    iter_upd;
        logic    div_init;
        logic    div_step;
        logic    out_load;
        wait_t   wait_on;
        branch_t branch;
        ustep_t  target;
    } ctrl_word_t;

    typedef struct packed {
        logic done;
        logic div_busy;
        logic out_free;
    } status_t;

    function automatic ctrl_word_t ucode_rom(input ustep_t s);
        ctrl_word_t w;
        begin
            w         = '0;
            w.wait_on = WAIT_NONE;
            w.branch  = BR_NEXT;
            w.target  = STEP_IDLE;
            unique case (s)
                STEP_IDLE:
                begin
                    w.load_in = 1'b1;
                    w.wait_on = WAIT_INPUT;
                end
                STEP_CMUL:
                begin
                    w.coord_mul = 1'b1;
                end
                STEP_CSUM:
                begin
                    w.coord_sum = 1'b1;
                end
                STEP_TMUL:
                begin
                    w.iter_mul = 1'b1;
                    w.branch   = BR_DONE;
                    w.target   = STEP_DINIT;
                end
                STEP_UPD:
                begin
                    w.iter_upd = 1'b1;
                    w.branch   = BR_ALWAYS;
                    w.target   = STEP_TMUL;
                end
                STEP_DINIT:
                begin
                    w.div_init = 1'b1;
                end
                STEP_DIV:
                begin
                    w.div_step = 1'b1;
                    w.wait_on  = WAIT_DIV;
                end
                STEP_OUT:
                begin
                    w.out_load = 1'b1;
                    w.wait_on  = WAIT_OUTPUT;
                    w.branch   = BR_ALWAYS;
                    w.target   = STEP_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

FILE: rtl/mep_sequencer.sv
// ----------------------------------------------------------------------------
// mep_sequencer: step counter and control store
// Fetches one control word per step, holds on wait conditions and takes
// unconditional jumps and conditional jumps on datapath status.
// ----------------------------------------------------------------------------
module mep_sequencer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  mep_pkg::status_t    status,
    output logic                in_ready,
    output mep_pkg::ctrl_word_t ctrl
);

    mep_pkg::ustep_t pc_reg;
    mep_pkg::ustep_t pc_next;
    logic            hold;
    logic            take;

    always_comb
    begin
        ctrl = mep_pkg::ucode_rom(pc_reg);
    end

    assign in_ready = ctrl.load_in;

    always_comb
    begin
        unique case (ctrl.wait_on)
            mep_pkg::WAIT_NONE:   hold = 1'b0;
            mep_pkg::WAIT_INPUT:  hold = !in_valid;
            mep_pkg::WAIT_OUTPUT: hold = !status.out_free;
            mep_pkg::WAIT_DIV:    hold = status.div_busy;
        endcase
    end

    always_comb
    begin
        unique case (ctrl.branch)
            mep_pkg::BR_NEXT:   take = 1'b0;
            mep_pkg::BR_ALWAYS: take = 1'b1;
            mep_pkg::BR_DONE:   take = status.done;
            default:            take = 1'b0;
        endcase
    end

    always_comb
    begin
        priority if (hold)
        begin
            pc_next = pc_reg;
        end
        else if (take)
        begin
            pc_next = ctrl.target;
        end
        else
        begin
            pc_next = pc_reg + 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= mep_pkg::STEP_IDLE;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

endmodule

FILE: rtl/mep_datapath.sv
// ----------------------------------------------------------------------------
// mep_datapath: coordinate, iteration, divider and output registers
// Executes the operations enabled by the control word: point mapping, the
// z*z + c step with Manhattan escape test, the gray-level divide and the
// result register.
// ----------------------------------------------------------------------------
module mep_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  mep_pkg::cfg_t       cfg,
    input  mep_pkg::ctrl_word_t ctrl,
    input  logic                in_valid,
    input  mep_pkg::pix_in_t    in_data,
    output mep_pkg::status_t    status,
    output logic                out_valid,
    input  logic                out_ready,
    output mep_pkg::pix_out_t   out_data
);

    localparam int F = mep_pkg::FRAC_BITS;

    // Input and coordinate registers
    logic [mep_pkg::IDX_W-1:0]   col_reg;
    logic [mep_pkg::IDX_W-1:0]   row_reg;
    logic [mep_pkg::CNT_W-1:0]   limit_reg;
    logic [mep_pkg::CPROD_W-1:0] pcr_reg;
    logic [mep_pkg::CPROD_W-1:0] pci_reg;
    logic [mep_pkg::C_W-1:0]     cre_reg;
    logic [mep_pkg::C_W-1:0]     cim_reg;

    // Iteration registers
    logic [mep_pkg::Z_W-1:0]           re_reg;
    logic [mep_pkg::Z_W-1:0]           im_reg;
    logic signed [mep_pkg::PROD_W-1:0] rr_reg;
    logic signed [mep_pkg::PROD_W-1:0] ii_reg;
    logic signed [mep_pkg::PROD_W-1:0] ri_reg;
    logic [mep_pkg::CNT_W-1:0]         it_reg;
    logic [mep_pkg::CNT_W-1:0]         count_reg;

    // Divider registers
    logic [mep_pkg::REM_W-1:0]  rem_reg;
    logic [mep_pkg::GRAY_W-1:0] quo_reg;
    logic [mep_pkg::DIVK_W-1:0] k_reg;

    // Output register
    logic                       out_valid_reg;
    logic [mep_pkg::CNT_W-1:0]  out_count_reg;
    logic [mep_pkg::GRAY_W-1:0] out_gray_reg;

    logic load_en;
    logic out_load_en;
    logic escape;

    logic [mep_pkg::CNT_W-1:0]         limit_in;
    logic [mep_pkg::C_W-1:0]           cre_next;
    logic [mep_pkg::C_W-1:0]           cim_next;
    logic signed [mep_pkg::OP_W-1:0]   re_op;
    logic signed [mep_pkg::OP_W-1:0]   im_op;
    logic [mep_pkg::Z_W-1:0]           re_mag;
    logic [mep_pkg::Z_W-1:0]           im_mag;
    logic [mep_pkg::NORM_W-1:0]        norm;
    logic signed [mep_pkg::PROD_W-1:0] diff;
    logic signed [mep_pkg::PROD_W-1:0] diff_sh;
    logic signed [mep_pkg::PROD_W-1:0] cross_sh;
    logic [mep_pkg::Z_W-1:0]           re_next;
    logic [mep_pkg::Z_W-1:0]           im_next;
    logic [mep_pkg::CNT_W-1:0]         count_next;
    logic [mep_pkg::REM_W-1:0]         rem_init;
    logic [mep_pkg::REM_W-1:0]         lim_sh;

    function automatic logic [mep_pkg::C_W-1:0] sat_coord(
        input logic [mep_pkg::C_W-1:0]     origin,
        input logic [mep_pkg::CPROD_W-1:0] prod
    );
        logic [mep_pkg::CSUM_W-1:0] sum;
        logic [mep_pkg::C_W-1:0]    res;
        begin
            sum = {{(mep_pkg::CSUM_W - mep_pkg::C_W){origin[mep_pkg::C_W-1]}}, origin}
                + {{(mep_pkg::CSUM_W - mep_pkg::CPROD_W){1'b0}}, prod};
            // Upper bits must all match the Q4.28 sign bit, else clamp
            if (sum[mep_pkg::CSUM_W-1:mep_pkg::C_W-1] == '0 ||
                sum[mep_pkg::CSUM_W-1:mep_pkg::C_W-1] == '1)
            begin
                res = sum[mep_pkg::C_W-1:0];
            end
            else if (sum[mep_pkg::CSUM_W-1])
            begin
                res = {1'b1, {(mep_pkg::C_W-1){1'b0}}};
            end
            else
            begin
                res = {1'b0, {(mep_pkg::C_W-1){1'b1}}};
            end
            return res;
        end
    endfunction

    assign load_en     = ctrl.load_in && in_valid;
    assign out_load_en = ctrl.out_load && status.out_free;

    assign limit_in = (cfg.max_iterations > mep_pkg::MAX_ITER_VAL) ?
                      mep_pkg::MAX_ITER_VAL : cfg.max_iterations;

    assign cre_next = sat_coord(cfg.origin_re, pcr_reg);
    assign cim_next = sat_coord(cfg.origin_im, pci_reg);

    // z fits the multiplier operand whenever it has not escaped
    assign re_op = signed'(re_reg[mep_pkg::OP_W-1:0]);
    assign im_op = signed'(im_reg[mep_pkg::OP_W-1:0]);

    assign re_mag = re_reg[mep_pkg::Z_W-1] ? (~re_reg + 1'b1) : re_reg;
    assign im_mag = im_reg[mep_pkg::Z_W-1] ? (~im_reg + 1'b1) : im_reg;
    assign norm   = {1'b0, re_mag} + {1'b0, im_mag};
    assign escape = norm > mep_pkg::ESC_BOUND;

    assign status.done = escape || (it_reg == limit_reg);
    assign count_next  = escape ? (it_reg - 1'b1) : limit_reg;

    assign diff     = rr_reg - ii_reg;
    assign diff_sh  = diff >>> F;
    assign cross_sh = ri_reg >>> (F - 1);
    assign re_next  = diff_sh[mep_pkg::Z_W-1:0]
                    + {{(mep_pkg::Z_W - mep_pkg::C_W){cre_reg[mep_pkg::C_W-1]}}, cre_reg};
    assign im_next  = cross_sh[mep_pkg::Z_W-1:0]
                    + {{(mep_pkg::Z_W - mep_pkg::C_W){cim_reg[mep_pkg::C_W-1]}}, cim_reg};

    // count * 255 as a shift and subtract
    assign rem_init = mep_pkg::REM_W'({count_reg, {mep_pkg::GRAY_W{1'b0}}}
                                      - {{mep_pkg::GRAY_W{1'b0}}, count_reg});
    assign lim_sh   = mep_pkg::REM_W'(limit_reg) << k_reg;

    assign status.div_busy = (k_reg != '0);
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            col_reg   <= in_data.pixel_col;
            row_reg   <= in_data.pixel_row;
            limit_reg <= limit_in;
            re_reg    <= '0;
            im_reg    <= '0;
            it_reg    <= '0;
        end
        if (ctrl.coord_mul)
        begin
            pcr_reg <= mep_pkg::CPROD_W'(col_reg) * mep_pkg::CPROD_W'(cfg.step_re);
            pci_reg <= mep_pkg::CPROD_W'(row_reg) * mep_pkg::CPROD_W'(cfg.step_im);
        end
        if (ctrl.coord_sum)
        begin
            cre_reg <= cre_next;
            cim_reg <= cim_next;
        end
        if (ctrl.iter_mul)
        begin
            rr_reg    <= mep_pkg::PROD_W'(re_op) * mep_pkg::PROD_W'(re_op);
            ii_reg    <= mep_pkg::PROD_W'(im_op) * mep_pkg::PROD_W'(im_op);
            ri_reg    <= mep_pkg::PROD_W'(re_op) * mep_pkg::PROD_W'(im_op);
            count_reg <= count_next;
        end
        if (ctrl.iter_upd)
        begin
            re_reg <= re_next;
            im_reg <= im_next;
            it_reg <= it_reg + 1'b1;
        end
        if (ctrl.div_init)
        begin
            rem_reg <= rem_init;
            quo_reg <= '0;
            k_reg   <= mep_pkg::DIVK_W'(mep_pkg::GRAY_W - 1);
        end
        if (ctrl.div_step)
        begin
            if (rem_reg >= lim_sh)
            begin
                rem_reg        <= rem_reg - lim_sh;
                quo_reg[k_reg] <= 1'b1;
            end
            k_reg <= k_reg - 1'b1;
        end
        if (out_load_en)
        begin
            out_count_reg <= count_reg;
            out_gray_reg  <= (limit_reg == '0) ? '0 : quo_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load_en)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid             = out_valid_reg;
    assign out_data.escape_count = out_count_reg;
    assign out_data.gray_level   = out_gray_reg;

`ifndef SYNTHESIS
    a_iter_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.iter_mul |-> it_reg <= limit_reg)
        else $error("iteration counter passed the limit");

    a_operand_fits: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.iter_mul && !escape) |->
            ((re_reg[mep_pkg::Z_W-1:mep_pkg::OP_W-1] == '0 ||
              re_reg[mep_pkg::Z_W-1:mep_pkg::OP_W-1] == '1) &&
             (im_reg[mep_pkg::Z_W-1:mep_pkg::OP_W-1] == '0 ||
              im_reg[mep_pkg::Z_W-1:mep_pkg::OP_W-1] == '1)))
        else $error("bounded z does not fit the multiplier operand");

    a_count_within_limit: assert property (@(posedge clk) disable iff (!rst_n)
        out_load_en |-> count_reg <= limit_reg)
        else $error("escape count above limit");

    a_div_remainder: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load_en && limit_reg != '0) |->
            rem_reg < mep_pkg::REM_W'(limit_reg))
        else $error("gray divide left a remainder not below the divisor");
`endif

endmodule

FILE: rtl/mandelbrot_escape_pixel_top.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_pixel_top: escape-time evaluation of one pixel per beat
// Maps a pixel index to a point c, iterates z = z*z + c with a Manhattan
// escape test and returns the escape count and a gray level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_ready/in_data carries one pixel (column, row)
//   per beat. Output channel out_valid/out_ready/out_data returns one beat
//   per pixel, in order: escape count and gray level.
//   Configuration writes go through cfg_we/cfg_index/cfg_data while the
//   block is idle; index codes beyond the register list are dropped.
// Sequence:
//   One pixel at a time, in this order: an accept step, the coordinate
//   multiply and saturate steps, then per iteration a 32x32 multiply and
//   an update, a final test, the 8-bit restoring divide (an init step,
//   then the quotient bit steps) and an output step. The next pixel is
//   taken only after the output step of the previous one. The multiply/update
//   loop of the control program sets the rate.
// Reset:
//   rst_n clears the step counter and the output valid flag and loads the
//   register defaults (limit 2048, origin -1.5 - 1.0i, step ~0.001).
// Stall:
//   A result waits in the output register; the next pixel is accepted and
//   worked on meanwhile, and the sequencer holds at the output step until
//   the waiting beat is taken.
// ----------------------------------------------------------------------------
module mandelbrot_escape_pixel_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  mep_pkg::pix_in_t                    in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output mep_pkg::pix_out_t                   out_data
);

    // Configuration registers: user writes only while block idle, not enforced
    mep_pkg::cfg_t       cfg_reg;
    mep_pkg::ctrl_word_t ctrl;
    mep_pkg::status_t    status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_iterations <= mep_pkg::RST_MAX_ITERATIONS;
            cfg_reg.origin_re      <= mep_pkg::RST_ORIGIN_RE;
            cfg_reg.origin_im      <= mep_pkg::RST_ORIGIN_IM;
            cfg_reg.step_re        <= mep_pkg::RST_STEP_RE;
            cfg_reg.step_im        <= mep_pkg::RST_STEP_IM;
        end
        else if (cfg_we)
        begin
            // Truncate the write data to each register's width
            unique case (cfg_index)
                mep_pkg::CFG_MAX_ITERATIONS:
                    cfg_reg.max_iterations <= cfg_data[mep_pkg::CNT_W-1:0];
                mep_pkg::CFG_ORIGIN_RE:
                    cfg_reg.origin_re <= cfg_data[mep_pkg::C_W-1:0];
                mep_pkg::CFG_ORIGIN_IM:
                    cfg_reg.origin_im <= cfg_data[mep_pkg::C_W-1:0];
                mep_pkg::CFG_STEP_RE:
                    cfg_reg.step_re <= cfg_data[mep_pkg::STEP_W-1:0];
                mep_pkg::CFG_STEP_IM:
                    cfg_reg.step_im <= cfg_data[mep_pkg::STEP_W-1:0];
                default:
                begin
                    // Drop writes to unmapped indexes
                end
            endcase
        end
    end

    // Control program: one control word per step
    mep_sequencer u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .in_ready (in_ready),
        .ctrl     (ctrl)
    );

    // Datapath driven by the control word; also owns the result register
    mep_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .ctrl      (ctrl),
        .in_valid  (in_valid),
        .in_data   (in_data),
        .status    (status),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

FILE: verif/mep_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mep_checker: escape-time predictor and result scoreboard
// Mirrors the configuration registers from the write port and predicts each
// pixel's escape count and gray level when its input beat is taken. Compares
// every output beat in order against the oldest prediction.
// ----------------------------------------------------------------------------
module mep_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mep_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mep_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                           in_valid,
    input  logic                           in_ready,
    input  mep_pkg::pix_in_t               in_data,
    input  logic                           out_valid,
    input  logic                           out_ready,
    input  mep_pkg::pix_out_t              out_data,
    output int                             fail_count,
    output int                             pending_count,
    output int                             checked_count
);
    import mep_pkg::*;

    cfg_t     regs;
    pix_out_t expected_pix[$];

    // Point coordinate in Q4.28, computed wide and clamped to 32-bit signed.
    function automatic longint point_coord(input logic [C_W-1:0] org,
                                           input logic [IDX_W-1:0] idx,
                                           input logic [STEP_W-1:0] stp);
        longint v;
        v = longint'($signed(org)) + longint'(idx) * longint'(stp);
        if (v > 64'sd2147483647)
            v = 64'sd2147483647;
        else if (v < -64'sd2147483648)
            v = -64'sd2147483648;
        return v;
    endfunction

    function automatic pix_out_t escape_time(input cfg_t r, input pix_in_t p);
        longint   lim;
        longint   cnt;
        longint   c_re;
        longint   c_im;
        longint   re;
        longint   im;
        longint   nre;
        longint   nim;
        longint   bound;
        pix_out_t res;
        lim = longint'(r.max_iterations);
        if (lim > MAX_ITER)
            lim = MAX_ITER;
        c_re  = point_coord(r.origin_re, p.pixel_col, r.step_re);
        c_im  = point_coord(r.origin_im, p.pixel_row, r.step_im);
        bound = 64'sd4 <<< FRAC_BITS;
        re    = 0;
        im    = 0;
        cnt   = lim;
        for (longint i = 0; i < lim; i++)
        begin
            nre = ((re * re - im * im) >>> FRAC_BITS) + c_re;
            nim = ((2 * re * im) >>> FRAC_BITS) + c_im;
            re  = nre;
            im  = nim;
            // norm equal to the bound still counts as bounded
            if ((re < 0 ? -re : re) + (im < 0 ? -im : im) > bound)
            begin
                cnt = i;
                break;
            end
        end
        res.escape_count = CNT_W'(cnt);
        res.gray_level   = (lim == 0) ? '0 : GRAY_W'((cnt * 255) / lim);
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        pix_out_t want;
        if (!rst_n)
        begin
            regs.max_iterations <= RST_MAX_ITERATIONS;
            regs.origin_re      <= RST_ORIGIN_RE;
            regs.origin_im      <= RST_ORIGIN_IM;
            regs.step_re        <= RST_STEP_RE;
            regs.step_im        <= RST_STEP_IM;
            expected_pix.delete();
            fail_count    <= 0;
            pending_count <= 0;
            checked_count <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_MAX_ITERATIONS: regs.max_iterations <= cfg_data[CNT_W-1:0];
                    CFG_ORIGIN_RE:      regs.origin_re      <= cfg_data[C_W-1:0];
                    CFG_ORIGIN_IM:      regs.origin_im      <= cfg_data[C_W-1:0];
                    CFG_STEP_RE:        regs.step_re        <= cfg_data[STEP_W-1:0];
                    CFG_STEP_IM:        regs.step_im        <= cfg_data[STEP_W-1:0];
                    default: ;
                endcase
            end
            if (out_valid && out_ready)
            begin
                if (expected_pix.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("[%0t] unexpected result beat: count=%0d gray=%0d",
                                 $realtime, out_data.escape_count, out_data.gray_level);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    want = expected_pix.pop_front();
                    checked_count <= checked_count + 1;
                    if (want.escape_count !== out_data.escape_count ||
                        want.gray_level !== out_data.gray_level)
                    begin
                        if (fail_count < 10)
                            $display("[%0t] mismatch: count exp %0d got %0d, gray exp %0d got %0d",
                                     $realtime, want.escape_count, out_data.escape_count,
                                     want.gray_level, out_data.gray_level);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_pix.push_back(escape_time(regs, in_data));
            pending_count <= expected_pix.size();
        end
    end

endmodule

FILE: verif/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: testbench top for the escape-time pixel block
// Drives pixel beats in random bursts under a series of register settings,
// stalls the result channel on its own pattern and lets the checker predict
// and compare every result. Prints the verdict once everything has drained.
// ----------------------------------------------------------------------------
module tb;
    import mep_pkg::*;

    // Unmapped register index; writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    pix_in_t               in_data;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    pix_out_t              out_data;

    int fail_count;
    int pending_count;
    int checked_count;
    int burst_left;
    int n_settings;
    int ready_run = 0;
    bit calm;

    always #5 clk = ~clk;

    mandelbrot_escape_pixel_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    mep_checker u_chk (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .in_data       (in_data),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .out_data      (out_data),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // Result receiver: alternate runs of ready and stall of random length.
    // In calm phases hold ready high so results stream out back to back.
    always @(posedge clk)
    begin
        if (ready_run > 0)
            ready_run <= ready_run - 1;
        else if (calm)
        begin
            out_ready <= 1'b1;
            ready_run <= 8;
        end
        else if ($urandom_range(0, 2) != 0)
        begin
            out_ready <= 1'b1;
            ready_run <= $urandom_range(0, 6);
        end
        else
        begin
            out_ready <= 1'b0;
            ready_run <= $urandom_range(0, 15);
        end
    end

    // Build one register setting.
    function automatic cfg_t make_cfg(input logic [CNT_W-1:0] lim,
                                      input logic [C_W-1:0] o_re,
                                      input logic [C_W-1:0] o_im,
                                      input logic [STEP_W-1:0] s_re,
                                      input logic [STEP_W-1:0] s_im);
        cfg_t c;
        c.max_iterations = lim;
        c.origin_re      = o_re;
        c.origin_im      = o_im;
        c.step_re        = s_re;
        c.step_im        = s_im;
        return c;
    endfunction

    // Write every register, one per cycle, then poke an unmapped index.
    // With junk set, fill the unused upper data bits with noise.
    // Only call this while the block is idle.
    task automatic load_config(input cfg_t c, input bit junk);
        logic [CFG_DATA_W-1:0] hi;
        hi = junk ? $urandom() : '0;
        cfg_we    <= 1'b1;
        cfg_index <= CFG_MAX_ITERATIONS;
        cfg_data  <= {hi[CFG_DATA_W-1:CNT_W], c.max_iterations};
        @(posedge clk);
        cfg_index <= CFG_ORIGIN_RE;
        cfg_data  <= c.origin_re;
        @(posedge clk);
        cfg_index <= CFG_ORIGIN_IM;
        cfg_data  <= c.origin_im;
        @(posedge clk);
        cfg_index <= CFG_STEP_RE;
        cfg_data  <= {hi[CFG_DATA_W-1], c.step_re};
        @(posedge clk);
        cfg_index <= CFG_STEP_IM;
        cfg_data  <= {hi[0], c.step_im};
        @(posedge clk);
        cfg_index <= CFG_UNMAPPED;
        cfg_data  <= $urandom();
        @(posedge clk);
        cfg_we    <= 1'b0;
        n_settings++;
    endtask

    // Send one pixel beat. At the start of a burst, drop valid for a random
    // gap (skipped in calm phases); within a burst, keep valid high and just
    // advance the payload at the accepting edge.
    task automatic send_pixel(input logic [IDX_W-1:0] col, input logic [IDX_W-1:0] row);
        int      gap;
        pix_in_t px;
        if (burst_left == 0)
        begin
            gap = calm ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12));
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 10);
        end
        px.pixel_col = col;
        px.pixel_row = row;
        in_valid <= 1'b1;
        in_data  <= px;
        do
            @(posedge clk);
        while (!in_ready);
        burst_left--;
    endtask

    // Drop valid after the last beat of a stretch and close the burst.
    task automatic pause_input();
        in_valid <= 1'b0;
        burst_left = 0;
    endtask

    // Hold until every predicted result has come back.
    task automatic drain();
        do
            @(posedge clk);
        while (pending_count != 0);
    endtask

    // Pick a random index, biased toward the edges of the field.
    function automatic logic [IDX_W-1:0] pick_index();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? '1 : '0;
        return $urandom_range(0, MAX_DIM - 1);
    endfunction

    initial
    begin
        int   wait_cycles;
        logic [CNT_W-1:0]  lim;
        logic [C_W-1:0]    o_re;
        logic [C_W-1:0]    o_im;
        logic [STEP_W-1:0] s_re;
        logic [STEP_W-1:0] s_im;

        rst_n      = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        burst_left = 0;
        n_settings = 0;
        calm       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset defaults: image corners
        send_pixel('0, '0);
        send_pixel('1, '1);
        send_pixel('0, '1);
        send_pixel('1, '0);
        pause_input();
        drain();

        // Zero limit: no iteration, count and gray both zero
        load_config(make_cfg('0, '0, '0, 31'd1, 31'd1), 1'b0);
        send_pixel('0, '0);
        send_pixel('1, '1);
        pause_input();
        drain();

        // Limit above the maximum saturates; c = 0 never escapes
        load_config(make_cfg('1, '0, '0, 31'd1, 31'd1), 1'b0);
        send_pixel('0, '0);
        pause_input();
        drain();

        // Limit exactly at the maximum; c = -1 cycles and stays bounded
        load_config(make_cfg(MAX_ITER_VAL, -32'sd268435456, '0, 31'd1, 31'd1), 1'b1);
        send_pixel('0, '0);
        pause_input();
        drain();

        // Single iteration
        load_config(make_cfg(13'd1, -32'sd536870912, -32'sd268435456,
                             31'd4096, 31'd4096), 1'b0);
        send_pixel('0, '0);
        send_pixel('1, '1);
        pause_input();
        drain();

        // Norm exactly 4 is not an escape; one lsb more is
        load_config(make_cfg(13'd8, 32'h4000_0000, '0, 31'd1, 31'd1), 1'b0);
        send_pixel('0, '0);
        send_pixel(12'd1, '0);
        send_pixel('0, 12'd1);
        pause_input();
        drain();

        // Out-of-range points saturate to the Q4.28 limits
        load_config(make_cfg(13'd16, 32'h7FFF_FFFF, 32'h8000_0000,
                             '1, '1), 1'b1);
        send_pixel('1, '0);
        send_pixel('0, '0);
        send_pixel('1, '1);
        pause_input();
        drain();

        // Random settings, each with a run of random pixels
        for (int ph = 0; ph < 8; ph++)
        begin
            calm = (ph == 3);
            if (ph == 1)
                lim = $urandom_range(300, 700);
            else if (ph == 6)
                lim = $urandom_range(1, 3);
            else
                lim = $urandom_range(4, 64);
            if (ph == 2 || ph == 5)
            begin
                // whole field: mostly saturated points that leave at once
                o_re = $urandom();
                o_im = $urandom();
                s_re = $urandom_range(1, 32'h7FFF_FFFF);
                s_im = $urandom_range(1, 32'h7FFF_FFFF);
            end
            else
            begin
                // frame around the set so counts spread over the limit
                o_re = -(5 << 27) + $urandom_range(0, 3 << 27);
                o_im = -(3 << 27) + $urandom_range(0, 1 << 28);
                s_re = $urandom_range(1, 1 << 18);
                s_im = $urandom_range(1, 1 << 18);
            end
            load_config(make_cfg(lim, o_re, o_im, s_re, s_im), ph[0]);
            for (int n = 0; n < 35; n++)
            begin
                send_pixel(pick_index(), pick_index());
                // hold off mid-run until the block has fully emptied
                if (ph == 4 && n == 17)
                begin
                    pause_input();
                    drain();
                end
            end
            pause_input();
            drain();
        end
        calm = 1'b0;

        // Let stray beats show up before the verdict
        for (wait_cycles = 0; pending_count != 0 && wait_cycles < 50000; wait_cycles++)
            @(posedge clk);
        repeat (40) @(posedge clk);

        $display("Run covered %0d pixel results over %0d register settings,",
                 checked_count, n_settings);
        $display("including zero and saturated limits, clamped points and the norm-4 edge.");
        if (fail_count == 0 && pending_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Watchdog: many times the slowest legal run
    initial
    begin
        #15_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

FILE: files.f
rtl/mep_pkg.sv
rtl/mep_sequencer.sv
rtl/mep_datapath.sv
rtl/mandelbrot_escape_pixel_top.sv
verif/mep_checker.sv
verif/tb.sv
